// File: rtl/core/chbd_pkg.sv
// ----------------------------------------------------------------------------
// chbd_pkg
// Types, constants and helper functions shared by the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_LF = 8'h0A;

    typedef enum logic [7:0] {
        PH_SIZE     = 8'b0000_0001,
        PH_SIZE_CR  = 8'b0000_0010,
        PH_DATA     = 8'b0000_0100,
        PH_DATA_CR  = 8'b0000_1000,
        PH_DATA_LF  = 8'b0001_0000,
        PH_TRAIL    = 8'b0010_0000,
        PH_TRAIL_CR = 8'b0100_0000,
        PH_DONE     = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        ERR_SIZE_LINE = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_NO_CRLF   = 2'd2
    } t_err;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] digit_count;
        logic       digits_done;
        logic       line_empty;
        logic       err_latched;
        t_err       err_kind;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{
        phase:       PH_SIZE,
        digit_count: 4'd0,
        digits_done: 1'b0,
        line_empty:  1'b1,
        err_latched: 1'b0,
        err_kind:    ERR_SIZE_LINE
    };

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       chunk_last;
        logic       body_done;
        logic       error_flag;
        logic [1:0] error_code;
    } t_res;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h = '{valid: 1'b0, value: 4'd0};
        if (b inside {[8'h30:8'h39]}) begin
            h = '{valid: 1'b1, value: 4'(b - 8'h30)};
        end else if (b inside {[8'h61:8'h66]}) begin
            h = '{valid: 1'b1, value: 4'(b - 8'h57)};
        end else if (b inside {[8'h41:8'h46]}) begin
            h = '{valid: 1'b1, value: 4'(b - 8'h37)};
        end
        return h;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

endpackage

// File: rtl/core/chbd_if.sv
// ----------------------------------------------------------------------------
// chbd_if
// Handshake channels of the chunked body decoder: input bytes and results.
// ----------------------------------------------------------------------------
interface chbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, in_byte, restart, input ready);
    modport sink   (input valid, in_byte, restart, output ready);
endinterface

interface chbd_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       chunk_last;
    logic       body_done;
    logic       error_flag;
    logic [1:0] error_code;

    modport source (output valid, data_valid, data_byte, chunk_last, body_done,
                    error_flag, error_code, input ready);
    modport sink   (input valid, data_valid, data_byte, chunk_last, body_done,
                    error_flag, error_code, output ready);
endinterface

// File: rtl/core/chbd_step.sv
// ----------------------------------------------------------------------------
// chbd_step
// Next-state and result logic for one body byte of the chunked decoder.
// ----------------------------------------------------------------------------
module chbd_step #(
    parameter int SIZE_BITS = 32
) (
    input  chbd_pkg::t_ctl        i_ctl,
    input  logic [SIZE_BITS-1:0]  i_rem,
    input  logic [7:0]            i_byte,
    input  logic                  i_restart,
    output chbd_pkg::t_ctl        o_ctl,
    output logic [SIZE_BITS-1:0]  o_rem,
    output chbd_pkg::t_res        o_res
);
    import chbd_pkg::*;

    t_ctl                 cur_ctl;
    logic [SIZE_BITS-1:0] cur_rem;
    t_hex                 hx;
    logic                 ws;
    logic                 dd_eff;
    logic                 take;
    t_ctl                 sb_ctl;
    logic [SIZE_BITS-1:0] sb_rem;
    t_ctl                 n_ctl;
    logic [SIZE_BITS-1:0] n_rem;
    logic                 valid;
    logic                 last;

    // Effect of one non-CR byte on a size line.
    always_comb begin
        cur_ctl = i_restart ? CTL_RESET : i_ctl;
        cur_rem = i_restart ? '0 : i_rem;
        hx      = hex_decode(i_byte);
        ws      = is_space(i_byte);
        dd_eff  = (cur_ctl.phase == PH_SIZE_CR && cur_ctl.digit_count != 4'd0)
                  ? 1'b1 : cur_ctl.digits_done;

        sb_ctl             = cur_ctl;
        sb_ctl.phase       = PH_SIZE;
        sb_ctl.digits_done = dd_eff;
        sb_rem             = cur_rem;
        take               = 1'b0;
        if (cur_ctl.digit_count == 4'd0) begin
            if (!ws) begin
                if (!hx.valid) begin
                    sb_ctl.err_latched = 1'b1;
                    sb_ctl.err_kind    = ERR_SIZE_LINE;
                end else begin
                    take = 1'b1;
                end
            end
        end else if (dd_eff || !hx.valid) begin
            sb_ctl.digits_done = 1'b1;
        end else begin
            take = 1'b1;
        end
        if (take) begin
            if (cur_rem[SIZE_BITS-1 -: 4] != 4'd0) begin
                sb_ctl.err_latched = 1'b1;
                sb_ctl.err_kind    = ERR_OVERFLOW;
            end else begin
                sb_rem = {cur_rem[SIZE_BITS-5:0], hx.value};
                if (cur_ctl.digit_count != 4'd15) begin
                    sb_ctl.digit_count = cur_ctl.digit_count + 4'd1;
                end
            end
        end
    end

    always_comb begin
        n_ctl = cur_ctl;
        n_rem = cur_rem;
        valid = 1'b0;
        last  = 1'b0;
        if (!cur_ctl.err_latched) begin
            case (cur_ctl.phase)
                PH_SIZE: begin
                    if (i_byte == CHR_CR) begin
                        n_ctl.phase = PH_SIZE_CR;
                    end else begin
                        n_ctl = sb_ctl;
                        n_rem = sb_rem;
                    end
                end
                PH_SIZE_CR: begin
                    if (i_byte == CHR_LF) begin
                        if (cur_ctl.digit_count == 4'd0) begin
                            n_ctl.err_latched = 1'b1;
                            n_ctl.err_kind    = ERR_SIZE_LINE;
                        end else if (cur_rem == '0) begin
                            n_ctl.phase      = PH_TRAIL;
                            n_ctl.line_empty = 1'b1;
                        end else begin
                            n_ctl.phase = PH_DATA;
                        end
                    end else if (i_byte == CHR_CR) begin
                        n_ctl.digits_done = dd_eff;
                    end else begin
                        n_ctl = sb_ctl;
                        n_rem = sb_rem;
                    end
                end
                PH_DATA: begin
                    valid = 1'b1;
                    n_rem = cur_rem - {{(SIZE_BITS-1){1'b0}}, 1'b1};
                    if (cur_rem == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
                        last        = 1'b1;
                        n_ctl.phase = PH_DATA_CR;
                    end
                end
                PH_DATA_CR: begin
                    if (i_byte == CHR_CR) begin
                        n_ctl.phase = PH_DATA_LF;
                    end else begin
                        n_ctl.err_latched = 1'b1;
                        n_ctl.err_kind    = ERR_NO_CRLF;
                    end
                end
                PH_DATA_LF: begin
                    if (i_byte == CHR_LF) begin
                        n_ctl.phase       = PH_SIZE;
                        n_ctl.digit_count = 4'd0;
                        n_ctl.digits_done = 1'b0;
                        n_rem             = '0;
                    end else begin
                        n_ctl.err_latched = 1'b1;
                        n_ctl.err_kind    = ERR_NO_CRLF;
                    end
                end
                PH_TRAIL: begin
                    if (i_byte == CHR_CR) begin
                        n_ctl.phase = PH_TRAIL_CR;
                    end else begin
                        n_ctl.line_empty = 1'b0;
                    end
                end
                PH_TRAIL_CR: begin
                    if (i_byte == CHR_LF) begin
                        if (cur_ctl.line_empty) begin
                            n_ctl.phase = PH_DONE;
                        end else begin
                            n_ctl.phase      = PH_TRAIL;
                            n_ctl.line_empty = 1'b1;
                        end
                    end else begin
                        n_ctl.line_empty = 1'b0;
                        if (i_byte != CHR_CR) begin
                            n_ctl.phase = PH_TRAIL;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ctl = n_ctl;
    assign o_rem = n_rem;

    assign o_res.data_valid = valid;
    assign o_res.data_byte  = valid ? i_byte : 8'd0;
    assign o_res.chunk_last = last;
    assign o_res.body_done  = (n_ctl.phase == PH_DONE);
    assign o_res.error_flag = n_ctl.err_latched;
    assign o_res.error_code = n_ctl.err_latched ? n_ctl.err_kind : ERR_SIZE_LINE;

endmodule

// File: rtl/core/chbd_obuf.sv
// ----------------------------------------------------------------------------
// chbd_obuf
// Result register with a skid entry, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module chbd_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  chbd_pkg::t_res i_res,
    output logic           o_ready,
    output logic           o_valid,
    output chbd_pkg::t_res o_res,
    input  logic           i_ready
);
    import chbd_pkg::*;

    logic r_out_vld;
    logic n_out_vld;
    t_res r_out;
    t_res n_out;
    logic r_skid_vld;
    logic n_skid_vld;
    t_res r_skid;
    t_res n_skid;
    logic in_fire;

    assign o_ready = !r_skid_vld;
    assign in_fire = i_valid && !r_skid_vld;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else if (in_fire) begin
                n_out     = i_res;
                n_out_vld = 1'b1;
            end else begin
                n_out_vld = 1'b0;
            end
        end else if (in_fire) begin
            n_skid     = i_res;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule

// File: rtl/core/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Byte-serial decoder of a chunked HTTP body; one result per input byte.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  i_in     in   in_byte, restart
//  o_out    out  data_valid, data_byte, chunk_last, body_done,
//                error_flag, error_code
//
// One byte is accepted per cycle while the skid entry is free; its result is
// registered. The decoder state is updated by a single pass of logic on each
// transaction. A result register with one skid entry lets input continue for
// one transaction while output stalls. Reset clears control and valid bits.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chbd_in_if.sink     i_in,
    chbd_out_if.source  o_out
);
    import chbd_pkg::*;

    t_ctl                 r_ctl;
    t_ctl                 n_ctl;
    logic [SIZE_BITS-1:0] r_rem;
    logic [SIZE_BITS-1:0] n_rem;
    t_res                 step_res;
    t_res                 out_res;
    logic                 in_fire;

    assign in_fire = i_in.valid && i_in.ready;

    chbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .i_ctl     (r_ctl),
        .i_rem     (r_rem),
        .i_byte    (i_in.in_byte),
        .i_restart (i_in.restart),
        .o_ctl     (n_ctl),
        .o_rem     (n_rem),
        .o_res     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= CTL_RESET;
            r_rem <= '0;
        end else if (in_fire) begin
            r_ctl <= n_ctl;
            r_rem <= n_rem;
        end
    end

    chbd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_res   (step_res),
        .o_ready (i_in.ready),
        .o_valid (o_out.valid),
        .o_res   (out_res),
        .i_ready (o_out.ready)
    );

    assign o_out.data_valid = out_res.data_valid;
    assign o_out.data_byte  = out_res.data_byte;
    assign o_out.chunk_last = out_res.chunk_last;
    assign o_out.body_done  = out_res.body_done;
    assign o_out.error_flag = out_res.error_flag;
    assign o_out.error_code = out_res.error_code;

endmodule
